// File: src/ftm_pkg.sv
// ----------------------------------------------------------------------------
// ftm_pkg
// shared types and constants of the filmic tone mapping core
// ----------------------------------------------------------------------------
package ftm_pkg;

    localparam int MAX_CHANNELS     = 4;
    localparam int DEF_NUM_CHANNELS = 4;
    localparam int IN_W             = 24;
    localparam int OUT_W            = 16;
    localparam int GAIN_W           = 16;
    localparam int T_W              = 24;
    localparam int P_W              = 27;
    localparam int NUM_W            = 51;
    localparam int DEN_W            = 51;

    localparam logic [GAIN_W-1:0] GAIN_RESET  = 16'd256;
    localparam logic [T_W-1:0]    SAT_Q816    = 24'hFFFFFF;
    localparam logic [T_W-1:0]    K_OFFSET    = 24'd262;
    localparam logic [18:0]       K_SIX_TWO   = 19'd406323;
    localparam logic [P_W-1:0]    K_HALF      = 27'd32768;
    localparam logic [P_W-1:0]    K_ONE_SEVEN = 27'd111411;
    localparam logic [DEN_W-1:0]  K_DEN_BIAS  = DEN_W'(3932) << 16;

    typedef struct packed {
        logic [IN_W-1:0] chan_red;
        logic [IN_W-1:0] chan_green;
        logic [IN_W-1:0] chan_blue;
        logic [IN_W-1:0] chan_fourth;
    } pixel_in_t;

    typedef struct packed {
        logic [OUT_W-1:0] mapped_red;
        logic [OUT_W-1:0] mapped_green;
        logic [OUT_W-1:0] mapped_blue;
        logic [OUT_W-1:0] mapped_fourth;
    } pixel_out_t;

endpackage

// File: src/ftm_channel.sv
// ----------------------------------------------------------------------------
// ftm_channel
// one channel pipeline: exposure, offset, rational curve, restoring divide
// ----------------------------------------------------------------------------
module ftm_channel (
    input  logic                      aclk,
    input  logic                      en,
    input  logic [ftm_pkg::IN_W-1:0]  x,
    input  logic [ftm_pkg::GAIN_W-1:0] gain,
    output logic [ftm_pkg::OUT_W-1:0] q
);
    import ftm_pkg::*;

    localparam int DIV_STEPS = OUT_W;
    localparam int PF_W      = 43;

    // stage 1: exposure product
    logic [IN_W+GAIN_W-1:0] prod_reg;
    // stage 2: saturate and offset
    logic [T_W-1:0] t_reg;
    // stage 3: shared product
    logic [T_W-1:0]  t3_reg;
    logic [PF_W-1:0] p_full_reg;
    // stage 4: numerator and denominator
    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    // divide stages
    logic [DEN_W-1:0]   rem_reg [DIV_STEPS];
    logic [DEN_W-1:0]   dd_reg  [DIV_STEPS];
    logic [OUT_W-1:0]   qq_reg  [DIV_STEPS];

    logic [IN_W+GAIN_W-9:0] s_w;
    logic [T_W-1:0]         s_sat;
    logic [P_W-1:0]         p_w;
    logic [P_W-1:0]         p_num;
    logic [P_W-1:0]         p_den;

    assign s_w   = prod_reg[IN_W+GAIN_W-1:8];
    assign s_sat = (s_w > {8'd0, SAT_Q816}) ? SAT_Q816 : s_w[T_W-1:0];
    assign p_w   = p_full_reg[PF_W-1:16];
    assign p_num = p_w + K_HALF;
    assign p_den = p_w + K_ONE_SEVEN;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg   <= (IN_W+GAIN_W)'(x) * (IN_W+GAIN_W)'(gain);
            t_reg      <= (s_sat > K_OFFSET) ? s_sat - K_OFFSET : '0;
            t3_reg     <= t_reg;
            p_full_reg <= PF_W'(K_SIX_TWO) * PF_W'(t_reg);
            num_reg    <= NUM_W'(t3_reg) * NUM_W'(p_num);
            den_reg    <= DEN_W'(t3_reg) * DEN_W'(p_den) + K_DEN_BIAS;
        end
    end

    genvar g;
    generate
        for (g = 0; g < DIV_STEPS; g++) begin : g_div
            logic [DEN_W-1:0] r_in;
            logic [DEN_W-1:0] d_in;
            logic [OUT_W-1:0] q_in;
            logic [DEN_W:0]   r_sh;
            if (g == 0) begin : g_first
                assign r_in = DEN_W'(num_reg);
                assign d_in = den_reg;
                assign q_in = '0;
            end else begin : g_next
                assign r_in = rem_reg[g-1];
                assign d_in = dd_reg[g-1];
                assign q_in = qq_reg[g-1];
            end
            assign r_sh = {r_in, 1'b0};
            always_ff @(posedge aclk) begin
                if (en) begin
                    dd_reg[g] <= d_in;
                    if (r_sh >= {1'b0, d_in}) begin
                        rem_reg[g] <= DEN_W'(r_sh - {1'b0, d_in});
                        qq_reg[g]  <= {q_in[OUT_W-2:0], 1'b1};
                    end else begin
                        rem_reg[g] <= r_sh[DEN_W-1:0];
                        qq_reg[g]  <= {q_in[OUT_W-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    assign q = qq_reg[DIV_STEPS-1];

endmodule

// File: src/filmic_tone_map_core.sv
// ----------------------------------------------------------------------------
// filmic_tone_map_core
// filmic tone mapping of four-channel q8.16 pixels to q0.16
// ----------------------------------------------------------------------------
// input items arrive on s_valid/s_ready/s_data, results leave on
// m_valid/m_ready/m_data, exposure gain is written on cfg_valid/cfg_ready
// one item per cycle is accepted while s_ready is high; 20 register stages
// (4 arithmetic, 16 divide stages of one quotient bit each), and an accepted
// item's valid bit passes through all of them before m_valid rises
// the pipeline moves as a whole: when the receiver stalls with a result
// waiting at the output, every stage holds, empty ones included, and
// s_ready drops, so nothing is lost or repeated
// reset clears all valid bits and loads the gain with 1.0
// channels at or beyond NUM_CHANNELS give zero
// ----------------------------------------------------------------------------
module filmic_tone_map_core #(
    parameter int NUM_CHANNELS = ftm_pkg::DEF_NUM_CHANNELS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ftm_pkg::pixel_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ftm_pkg::pixel_out_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [ftm_pkg::GAIN_W-1:0] cfg_data
);
    import ftm_pkg::*;

    localparam int DEPTH = 4 + OUT_W;

    logic [GAIN_W-1:0] gain_reg;
    logic [DEPTH-1:0]  vld_reg;
    logic              en;
    logic [IN_W-1:0]   xin [MAX_CHANNELS];
    logic [OUT_W-1:0]  qo  [MAX_CHANNELS];

    assign en        = !vld_reg[DEPTH-1] || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;
    assign m_valid   = vld_reg[DEPTH-1];

    assign xin[0] = s_data.chan_red;
    assign xin[1] = s_data.chan_green;
    assign xin[2] = s_data.chan_blue;
    assign xin[3] = s_data.chan_fourth;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= GAIN_RESET;
            vld_reg  <= '0;
        end else begin
            if (cfg_valid) begin
                gain_reg <= cfg_data;
            end
            if (en) begin
                vld_reg <= {vld_reg[DEPTH-2:0], s_valid};
            end
        end
    end

    genvar c;
    generate
        for (c = 0; c < MAX_CHANNELS; c++) begin : g_ch
            if (c < NUM_CHANNELS) begin : g_on
                ftm_channel u_ch (
                    .aclk (aclk),
                    .en   (en),
                    .x    (xin[c]),
                    .gain (gain_reg),
                    .q    (qo[c])
                );
            end else begin : g_off
                assign qo[c] = '0;
            end
        end
    endgenerate

    assign m_data.mapped_red    = qo[0];
    assign m_data.mapped_green  = qo[1];
    assign m_data.mapped_blue   = qo[2];
    assign m_data.mapped_fourth = qo[3];

endmodule

// File: tb/filmic_tone_map_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// filmic_tone_map_checker
// watches the pixel channels and the gain port, predicts each tone mapped
// pixel with a fixed point model of the curve and compares it as a whole pixel
// ----------------------------------------------------------------------------
module filmic_tone_map_checker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  ftm_pkg::pixel_in_t         s_data,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  ftm_pkg::pixel_out_t        m_data,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [ftm_pkg::GAIN_W-1:0] cfg_data,
    output int                         fail_count,
    output int                         pending,
    output int                         pixels_seen
);
    import ftm_pkg::*;

    logic [GAIN_W-1:0] gain_shadow;
    pixel_out_t        mapped_queue[$];

    function automatic logic [OUT_W-1:0] tone_curve(logic [IN_W-1:0] x,
                                                    logic [GAIN_W-1:0] g);
        logic [63:0] s;
        logic [63:0] t;
        logic [63:0] p;
        logic [63:0] num;
        logic [63:0] den;
        logic [79:0] q;
        s = (64'(x) * 64'(g)) >> 8;
        if (s > 64'hFFFFFF) s = 64'hFFFFFF;
        t = (s > 64'd262) ? s - 64'd262 : 64'd0;
        p = (64'd406323 * t) >> 16;
        num = t * (p + 64'd32768);
        den = t * (p + 64'd111411) + (64'd3932 << 16);
        q = ({16'd0, num} << 16) / {16'd0, den};
        return q[OUT_W-1:0];
    endfunction

    function automatic pixel_out_t map_pixel(pixel_in_t px, logic [GAIN_W-1:0] g);
        pixel_out_t r;
        r.mapped_red    = tone_curve(px.chan_red, g);
        r.mapped_green  = tone_curve(px.chan_green, g);
        r.mapped_blue   = tone_curve(px.chan_blue, g);
        r.mapped_fourth = tone_curve(px.chan_fourth, g);
        return r;
    endfunction

    assign pending = mapped_queue.size();

    always_ff @(posedge aclk) begin
        pixel_out_t want;
        if (!aresetn) begin
            gain_shadow <= GAIN_RESET;
            fail_count  <= 0;
            pixels_seen <= 0;
            mapped_queue.delete();
        end else begin
            if (s_valid && s_ready)
                mapped_queue.push_back(map_pixel(s_data, gain_shadow));
            if (cfg_valid && cfg_ready)
                gain_shadow <= cfg_data;
            if (m_valid && m_ready) begin
                pixels_seen <= pixels_seen + 1;
                if (mapped_queue.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected item %h", m_data);
                    fail_count <= fail_count + 1;
                end else begin
                    want = mapped_queue.pop_front();
                    if (want !== m_data) begin
                        if (fail_count < 10)
                            $display("mismatch: expected r%h g%h b%h f%h, got r%h g%h b%h f%h",
                                     want.mapped_red, want.mapped_green,
                                     want.mapped_blue, want.mapped_fourth,
                                     m_data.mapped_red, m_data.mapped_green,
                                     m_data.mapped_blue, m_data.mapped_fourth);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// File: tb/filmic_tone_map_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// filmic_tone_map_core_test
// drives pixels in random bursts under several exposure gains, stalls the
// output on its own pattern and takes the verdict from the checker
// ----------------------------------------------------------------------------
module filmic_tone_map_core_test;
    import ftm_pkg::*;

    localparam int LIMIT = 400000;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    pixel_in_t         s_data;
    logic              m_valid;
    logic              m_ready;
    pixel_out_t        m_data;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [GAIN_W-1:0] cfg_data;
    int                fail_count;
    int                pending;
    int                pixels_seen;
    int                cycle_count;
    int                stall_phase;

    filmic_tone_map_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    filmic_tone_map_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending), .pixels_seen(pixels_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // receiver stall pattern: quiet stretches, then random, then heavy
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        stall_phase = (cycle_count / 700) % 3;
        case (stall_phase)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            default: m_ready <= ($urandom_range(0, 3) == 0);
        endcase
        if (cycle_count > LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [IN_W-1:0] rand_chan();
        case ($urandom_range(0, 5))
            0: return IN_W'($urandom_range(0, 600));
            1: return IN_W'($urandom_range(0, 24'h3FFFF));
            2: return 24'hFFFFFF - IN_W'($urandom_range(0, 15));
            default: return IN_W'($urandom);
        endcase
    endfunction

    task automatic send_pixel(pixel_in_t px);
        s_valid <= 1'b1;
        s_data  <= px;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic write_gain(logic [GAIN_W-1:0] g);
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= g;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_burst_run(int count);
        int left;
        int burst;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && left > 0) begin
                send_pixel('{rand_chan(), rand_chan(), rand_chan(), rand_chan()});
                burst--;
                left--;
            end
            if ($urandom_range(0, 2) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
        s_valid <= 1'b0;
    endtask

    initial begin
        logic [GAIN_W-1:0] gains[6];
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        m_ready     = 1'b0;
        cycle_count = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset gain: zero, offset edge, small, max and mixed pixels
        send_pixel('{24'd0, 24'd261, 24'd262, 24'd263});
        send_pixel('{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF});
        send_pixel('{24'h010000, 24'h008000, 24'h000001, 24'h800000});
        send_pixel('{24'hAAAAAA, 24'h555555, 24'h0F0F0F, 24'hF0F0F0});
        s_valid <= 1'b0;

        gains = '{16'd0, 16'hFFFF, 16'd1, 16'h0080, 16'h1000, 16'd256};
        foreach (gains[i]) begin
            write_gain(gains[i]);
            send_pixel('{24'd0, 24'hFFFFFF, 24'h010000, 24'd300});
            send_pixel('{24'h555555, 24'hAAAAAA, 24'h000105, 24'h7FFFFF});
            s_valid <= 1'b0;
            write_gain(16'($urandom));
            random_burst_run(300);
        end

        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        $display("checked %0d tone mapped pixels across thirteen exposure gains,", pixels_seen);
        $display("including zero, unity, minimum and maximum gain");
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
